// ----- src/suvt_pkg.sv -----
// ----------------------------------------------------------------------------
// suvt_pkg: shared types and codes for the sorted unique value table
// Command and result words, cell control word, operation and status codes.
// ----------------------------------------------------------------------------
package suvt_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam logic [15:0] TOL_RESET = 16'd7;

    localparam logic [2:0] MODE_INSERT  = 3'd0;
    localparam logic [2:0] MODE_DELETE  = 3'd1;
    localparam logic [2:0] MODE_REPLACE = 3'd2;
    localparam logic [2:0] MODE_SET     = 3'd3;
    localparam logic [2:0] MODE_READ    = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] old_value;
        logic signed [31:0] new_value;
        logic [5:0]         index;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         count;
        logic [2:0]         status;
    } result_t;

    typedef enum logic [2:0] {
        CELL_NONE,
        CELL_INSERT,
        CELL_REM_NEAR,
        CELL_REM_EXACT,
        CELL_REM_INDEX
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic        commit;
        logic [31:0] key;
        logic [15:0] tol;
        logic [5:0]  idx;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_FIRST,
        FSM_SECOND
    } fsm_t;

endpackage

// ----- src/suvt_cell.sv -----
// ----------------------------------------------------------------------------
// suvt_cell: one slot of the sorted table
// Compares its entry against the broadcast key and shifts with its neighbors.
// ----------------------------------------------------------------------------
module suvt_cell #(
    parameter int POS   = 0,
    parameter int CNT_W = 7
) (
    input  logic                 clk,
    input  suvt_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]     count,
    input  logic                 left_flag,
    input  logic [31:0]          left_entry,
    input  logic [31:0]          right_entry,
    output logic [31:0]          entry,
    output logic                 flag,
    output logic                 hit
);
    import suvt_pkg::*;

    logic [31:0]        entry_reg;
    logic [31:0]        entry_next;
    logic               valid;
    logic signed [33:0] diff;
    logic signed [33:0] tol_s;

    assign entry = entry_reg;
    assign valid = count > CNT_W'(POS);
    assign diff  = $signed({{2{entry_reg[31]}}, entry_reg})
                 - $signed({{2{ctrl.key[31]}}, ctrl.key});
    assign tol_s = $signed({18'b0, ctrl.tol});

    // flag is the monotone split of the row: below key for insert,
    // at or past the removal point for the remove kinds
    always_comb
    begin
        flag = 1'b0;
        hit  = 1'b0;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                flag = valid && ($signed(entry_reg) < $signed(ctrl.key));
                hit  = valid && (entry_reg == ctrl.key);
            end
            CELL_REM_NEAR:
            begin
                flag = valid && (diff > -tol_s);
                hit  = flag && (diff < tol_s);
            end
            CELL_REM_EXACT:
            begin
                flag = valid && ($signed(entry_reg) >= $signed(ctrl.key));
                hit  = valid && (entry_reg == ctrl.key);
            end
            CELL_REM_INDEX:
            begin
                flag = valid && (POS >= int'(ctrl.idx));
                hit  = valid && (POS == int'(ctrl.idx));
            end
            CELL_NONE:
            begin
                flag = 1'b0;
                hit  = 1'b0;
            end
            default:
            begin
                flag = 1'b0;
                hit  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.commit)
        begin
            if (ctrl.op == CELL_INSERT)
            begin
                // hold below the key, take the key at the split, shift up past it
                if (!flag)
                begin
                    entry_next = left_flag ? ctrl.key : left_entry;
                end
            end
            else if (flag)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- src/sorted_unique_value_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_unique_value_table_top: ascending table of unique Q16.16 words
// Each word runs the FIRST pass (whole operation or removal half), then the
//   SECOND pass (insert) for a replace or set that finds its target; done
//   and the result word are registered after the last pass. A new word is
//   taken only while idle; each pass compares in the cell row, then shifts.
// Reset clears the entry count and loads the delete tolerance with 7; the
//   receiver cannot stall, so done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module sorted_unique_value_table_top #(
    parameter int CAPACITY = suvt_pkg::CAPACITY_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  suvt_pkg::cmd_t    cmd,
    output logic              done,
    output suvt_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata
);
    import suvt_pkg::*;

    // count holds 0..CAPACITY; index compares run at the wider of count and
    // the 7-bit count field
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    fsm_t               state_reg;
    fsm_t               state_next;
    cmd_t               cmd_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [15:0]        tol_reg;
    result_t            res_reg;
    result_t            res_next;
    logic               done_reg;
    logic               done_next;

    cell_ctrl_t                ctrl;
    logic [CAPACITY-1:0][31:0] entries;
    logic [CAPACITY-1:0]       flags;
    logic [CAPACITY-1:0]       hits;
    logic                      any_hit;
    logic                      idx_ok;
    logic                      full;
    logic [31:0]               rd_data;

    assign busy   = (state_reg != FSM_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // ------------------------------------------------------------------
    // Cell row: each cell sees the broadcast control word and the entries
    // of both neighbors. The first cell sees a split on its left, the last
    // cell takes its own entry when the row shifts down.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic        left_flag;
        logic [31:0] left_entry;
        logic [31:0] right_entry;

        if (g == 0)
        begin : g_first
            assign left_flag  = 1'b1;
            assign left_entry = ctrl.key;
        end
        else
        begin : g_mid
            assign left_flag  = flags[g-1];
            assign left_entry = entries[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_entry = entries[g];
        end
        else
        begin : g_body
            assign right_entry = entries[g+1];
        end

        suvt_cell #(
            .POS   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_flag   (left_flag),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[g]),
            .flag        (flags[g]),
            .hit         (hits[g])
        );
    end

    assign any_hit = |hits;
    assign idx_ok  = CMP_W'(cmd_reg.index) < CMP_W'(count_reg);
    assign full    = count_reg >= CNT_W'(CAPACITY);

    // Read data: at most one cell hits on an index compare, so OR the row
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_data = rd_data | (hits[i] ? entries[i] : 32'd0);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: FIRST does the whole operation or its removal half,
    // SECOND inserts the new value after a replace or set removal.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        ctrl.op     = CELL_NONE;
        ctrl.commit = 1'b0;
        ctrl.key    = cmd_reg.new_value;
        ctrl.tol    = tol_reg;
        ctrl.idx    = cmd_reg.index;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = FSM_FIRST;
                end
            end
            FSM_FIRST:
            begin
                state_next          = FSM_IDLE;
                done_next           = 1'b1;
                res_next.read_value = '0;
                res_next.status     = ST_OK;
                unique case (cmd_reg.mode)
                    MODE_INSERT:
                    begin
                        ctrl.op     = CELL_INSERT;
                        ctrl.commit = !any_hit && !full;
                        if (any_hit)
                        begin
                            res_next.status = ST_DUP;
                        end
                        else if (full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    MODE_DELETE:
                    begin
                        ctrl.op     = CELL_REM_NEAR;
                        ctrl.key    = cmd_reg.old_value;
                        ctrl.commit = any_hit;
                        if (any_hit)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            res_next.status = ST_NOTFOUND;
                        end
                    end
                    MODE_REPLACE:
                    begin
                        ctrl.op     = CELL_REM_EXACT;
                        ctrl.key    = cmd_reg.old_value;
                        ctrl.commit = any_hit;
                        if (any_hit)
                        begin
                            // hold the result back for the insert pass
                            count_next = count_reg - 1'b1;
                            state_next = FSM_SECOND;
                            done_next  = 1'b0;
                        end
                        else
                        begin
                            res_next.status = ST_NOTFOUND;
                        end
                    end
                    MODE_SET:
                    begin
                        ctrl.op     = CELL_REM_INDEX;
                        ctrl.commit = idx_ok;
                        if (idx_ok)
                        begin
                            count_next = count_reg - 1'b1;
                            state_next = FSM_SECOND;
                            done_next  = 1'b0;
                        end
                        else
                        begin
                            res_next.status = ST_RANGE;
                        end
                    end
                    MODE_READ:
                    begin
                        // index compare without commit: only the read hit
                        ctrl.op = CELL_REM_INDEX;
                        if (idx_ok)
                        begin
                            res_next.read_value = rd_data;
                        end
                        else
                        begin
                            res_next.status = ST_RANGE;
                        end
                    end
                    default:
                    begin
                        ctrl.op = CELL_NONE;
                    end
                endcase
                res_next.count = 7'(count_next);
            end
            FSM_SECOND:
            begin
                // one slot was just freed, so the table cannot be full here
                state_next          = FSM_IDLE;
                done_next           = 1'b1;
                ctrl.op             = CELL_INSERT;
                ctrl.commit         = !any_hit;
                res_next.read_value = '0;
                res_next.status     = any_hit ? ST_DUP : ST_OK;
                if (!any_hit)
                begin
                    count_next = count_reg + 1'b1;
                end
                res_next.count = 7'(count_next);
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            count_reg <= '0;
            tol_reg   <= TOL_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    // payload registers: latch the command word, hold the result word
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        res_reg <= res_next;
    end

endmodule

// ----- src/suvt_checker.sv -----
// ----------------------------------------------------------------------------
// suvt_checker: port-level checks for the sorted unique value table
// Watches the command and result handshake and the result word contents.
// ----------------------------------------------------------------------------
module suvt_checker #(
    parameter int CAPACITY = suvt_pkg::CAPACITY_DEFAULT
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input suvt_pkg::result_t result
);
    import suvt_pkg::*;

    // an accepted word keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // the result strobe arrives only once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // a failed operation returns zero read data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |-> (result.read_value == 32'sd0))
        else $error("nonzero read data on failed operation");

    // the reported count never exceeds the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(result.count) <= CAPACITY))
        else $error("count beyond capacity");

endmodule

bind sorted_unique_value_table_top suvt_checker #(
    .CAPACITY (CAPACITY)
) u_suvt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
